>>> rtl/core/lcdws_pkg.sv
// lcdws_pkg: shared types, constants and the microcode ROM of the LCD write sequencer.
// No dependencies.
package lcdws_pkg;

	localparam int LINE_COLUMNS_DEF = 16;

	localparam int PC_W = 4;

	localparam logic [7:0] PULSE_MS     = 8'd2;
	localparam logic [7:0] BYTE_TAIL_MS = 8'd3;   // pulse low time plus byte idle
	localparam logic [7:0] POWER_UP_MS  = 8'd200;

	localparam logic [7:0] DDRAM_ROW1 = 8'h80;
	localparam logic [7:0] DDRAM_ROW2 = 8'hC0;

	// request codes
	localparam logic [2:0] MODE_INIT   = 3'd0;
	localparam logic [2:0] MODE_CMD    = 3'd1;
	localparam logic [2:0] MODE_CHAR   = 3'd2;
	localparam logic [2:0] MODE_CURSOR = 3'd3;
	localparam logic [2:0] MODE_CLEAR  = 3'd4;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_BUS8,
		COND_BUS4
	} bus_cond_t;

	typedef struct packed {
		logic        power_up;    // single all-zero 200 ms phase
		logic        use_latch;   // byte from the latched request, else const_byte
		logic [7:0]  const_byte;
		logic        rs;
		logic [3:0]  extra_ms;
		bus_cond_t   bus_cond;    // step skipped when the bus width does not match
		logic        end_prog;
	} ucode_t;

	// program entry points
	localparam logic [PC_W-1:0] PC_INIT   = 4'd0;
	localparam logic [PC_W-1:0] PC_CMD    = 4'd7;
	localparam logic [PC_W-1:0] PC_CHAR   = 4'd8;
	localparam logic [PC_W-1:0] PC_CURSOR = 4'd9;
	localparam logic [PC_W-1:0] PC_CLEAR  = 4'd10;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{power_up: 1'b0, use_latch: 1'b0, const_byte: 8'h00, rs: 1'b0,
			extra_ms: 4'd0, bus_cond: COND_ALWAYS, end_prog: 1'b1};
		unique case (pc)
			4'd0: begin
				w.power_up = 1'b1;
				w.end_prog = 1'b0;
			end
			4'd1: begin
				w.const_byte = 8'h02; w.extra_ms = 4'd10;
				w.bus_cond = COND_BUS4; w.end_prog = 1'b0;
			end
			4'd2: begin
				w.const_byte = 8'h28; w.extra_ms = 4'd1;
				w.bus_cond = COND_BUS4; w.end_prog = 1'b0;
			end
			4'd3: begin
				w.const_byte = 8'h38; w.extra_ms = 4'd1;
				w.bus_cond = COND_BUS8; w.end_prog = 1'b0;
			end
			4'd4: begin
				w.const_byte = 8'h0E; w.extra_ms = 4'd1; w.end_prog = 1'b0;
			end
			4'd5: begin
				w.const_byte = 8'h01; w.extra_ms = 4'd10; w.end_prog = 1'b0;
			end
			4'd6: begin
				w.const_byte = 8'h06; w.extra_ms = 4'd1;
			end
			4'd7: begin
				w.use_latch = 1'b1;
			end
			4'd8: begin
				w.use_latch = 1'b1; w.rs = 1'b1;
			end
			4'd9: begin
				w.use_latch = 1'b1; w.extra_ms = 4'd1;
			end
			4'd10: begin
				w.const_byte = 8'h01; w.extra_ms = 4'd10;
			end
			default: begin
				w.end_prog = 1'b1;
			end
		endcase
		return w;
	endfunction

	function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] m);
		logic [PC_W-1:0] pc;
		pc = PC_INIT;
		unique case (m)
			MODE_INIT:   pc = PC_INIT;
			MODE_CMD:    pc = PC_CMD;
			MODE_CHAR:   pc = PC_CHAR;
			MODE_CURSOR: pc = PC_CURSOR;
			MODE_CLEAR:  pc = PC_CLEAR;
			default:     pc = PC_INIT;
		endcase
		return pc;
	endfunction

endpackage

>>> rtl/core/lcdws_cursor_cmd.sv
// lcdws_cursor_cmd: row/column to set-DDRAM-address command byte.
// Depends on lcdws_pkg.
module lcdws_cursor_cmd #(
	parameter int LINE_COLUMNS = lcdws_pkg::LINE_COLUMNS_DEF
) (
	input  logic [7:0] row,
	input  logic [7:0] column,
	output logic [7:0] cmd
);

	logic in_range;

	always_comb begin
		in_range = (column != 8'd0) && (column <= 8'(LINE_COLUMNS)) &&
			((row == 8'd1) || (row == 8'd2));
		if (!in_range)
			cmd = lcdws_pkg::DDRAM_ROW1;
		else if (row == 8'd1)
			cmd = lcdws_pkg::DDRAM_ROW1 + column - 8'd1;
		else
			cmd = lcdws_pkg::DDRAM_ROW2 + column - 8'd1;
	end

endmodule

>>> rtl/core/char_lcd_write_sequencer.sv
// char_lcd_write_sequencer: one request in, a list of timed LCD bus phases out.
// The request moves the sequencer into the run state; phases are then registered onto
// the outputs one phase a cycle; a step skipped by the bus-width test shows no phase.
// The receiver cannot stall; each phase shows for one cycle with strobe high.
// Reset (arst_n low) clears the sequencer to idle and bus_mode to eight-bit.
// Depends on lcdws_pkg and lcdws_cursor_cmd.
module char_lcd_write_sequencer #(
	parameter int LINE_COLUMNS = lcdws_pkg::LINE_COLUMNS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       bus_mode_we,
	input  logic       bus_mode_wdata,
	// request
	input  logic       start,
	output logic       busy,
	input  logic [2:0] mode,
	input  logic [7:0] byte_value,
	input  logic [7:0] row,
	input  logic [7:0] column,
	// phase output
	output logic       strobe,
	output logic [7:0] data_lines,
	output logic       reg_select,
	output logic       enable,
	output logic [7:0] hold_ms,
	output logic       last
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                        state_q;
	logic [lcdws_pkg::PC_W-1:0]    pc_q;
	logic [1:0]                    ph_q;      // phase within a byte
	logic [7:0]                    byte_q;    // latched request byte
	logic                          bus_mode_q;

	logic                          strobe_q;
	logic [7:0]                    data_q;
	logic                          rs_q;
	logic                          en_q;
	logic [7:0]                    hold_q;
	logic                          last_q;

	logic [7:0]                    cursor_cmd;
	lcdws_pkg::ucode_t             cw;
	logic                          accept;
	logic                          mode_ok;
	logic                          step_on;   // step passes its bus-width test
	logic                          final_ph;  // last phase of this step
	logic [7:0]                    cur_byte;
	logic [7:0]                    ph_data;
	logic                          ph_en;
	logic [7:0]                    ph_hold;

	lcdws_cursor_cmd #(
		.LINE_COLUMNS(LINE_COLUMNS)
	) u_cursor (
		.row    (row),
		.column (column),
		.cmd    (cursor_cmd)
	);

	assign busy    = (state_q == ST_RUN);
	assign accept  = start && !busy;
	assign mode_ok = (mode <= lcdws_pkg::MODE_CLEAR);

	// Microcode word for the current step.
	assign cw = lcdws_pkg::ucode_rom(pc_q);

	always_comb begin
		unique case (cw.bus_cond)
			lcdws_pkg::COND_BUS8: step_on = !bus_mode_q;
			lcdws_pkg::COND_BUS4: step_on = bus_mode_q;
			default:              step_on = 1'b1;
		endcase

		cur_byte = cw.use_latch ? byte_q : cw.const_byte;

		// Phase decode: even phases drive enable high; in four-bit mode
		// phases 0/1 carry the high nibble, 2/3 the low nibble.
		if (cw.power_up)
			final_ph = 1'b1;
		else if (bus_mode_q)
			final_ph = (ph_q == 2'd3);
		else
			final_ph = (ph_q == 2'd1);

		ph_en = !ph_q[0] && !cw.power_up;

		if (cw.power_up)
			ph_data = 8'h00;
		else if (!bus_mode_q)
			ph_data = cur_byte;
		else if (ph_q[1])
			ph_data = {cur_byte[3:0], 4'h0};
		else
			ph_data = {cur_byte[7:4], 4'h0};

		// Byte idle and request settle time fold into the final low phase.
		if (cw.power_up)
			ph_hold = lcdws_pkg::POWER_UP_MS;
		else if (final_ph)
			ph_hold = lcdws_pkg::BYTE_TAIL_MS + {4'h0, cw.extra_ms};
		else
			ph_hold = lcdws_pkg::PULSE_MS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pc_q       <= lcdws_pkg::PC_INIT;
			ph_q       <= 2'd0;
			bus_mode_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (bus_mode_we)
				bus_mode_q <= bus_mode_wdata;

			unique case (state_q)
				ST_IDLE: begin
					// unknown request codes are dropped without a transaction
					if (accept && mode_ok) begin
						state_q <= ST_RUN;
						pc_q    <= lcdws_pkg::entry_pc(mode);
						ph_q    <= 2'd0;
					end
				end
				ST_RUN: begin
					if (!step_on) begin
						pc_q <= pc_q + 4'd1;
						ph_q <= 2'd0;
					end else begin
						strobe_q <= 1'b1;
						if (final_ph) begin
							ph_q <= 2'd0;
							if (cw.end_prog)
								state_q <= ST_IDLE;
							else
								pc_q <= pc_q + 4'd1;
						end else begin
							ph_q <= ph_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (accept)
			byte_q <= (mode == lcdws_pkg::MODE_CURSOR) ? cursor_cmd : byte_value;
		if (busy && step_on) begin
			data_q <= ph_data;
			rs_q   <= cw.rs;
			en_q   <= ph_en;
			hold_q <= ph_hold;
			last_q <= final_ph && cw.end_prog;
		end
	end

	assign strobe     = strobe_q;
	assign data_lines = data_q;
	assign reg_select = rs_q;
	assign enable     = en_q;
	assign hold_ms    = hold_q;
	assign last       = last_q;

endmodule
